// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = 32 / DIV_BITS_PER_STAGE;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_INC      = 4'd6,
    CMD_DEC      = 4'd7,
    CMD_INT2FIX  = 4'd8,
    CMD_FIX2INT  = 4'd9
  } cmd_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less_b;
    logic               a_equal_b;
    logic               a_greater_b;
    logic               divide_by_zero;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        neg;
    logic        dz;
    logic        ovf;
    logic [63:0] prod;
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] lo;
    logic [31:0] q;
  } pipe_t;

endpackage

// ===== rtl/fpa_div_pipe.sv =====
module fpa_div_pipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          din_vld,
  input  fpa_pkg::pipe_t din,
  output logic          dout_vld,
  output fpa_pkg::pipe_t dout
);

  localparam int NS = fpa_pkg::DIV_STAGES;
  localparam int NB = fpa_pkg::DIV_BITS_PER_STAGE;

  fpa_pkg::pipe_t st [NS];
  fpa_pkg::pipe_t st_next [NS];
  logic [NS-1:0]  vld;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    always_comb begin
      fpa_pkg::pipe_t p;
      logic [32:0]    r33;
      p = (k == 0) ? din : st[(k == 0) ? 0 : k-1];
      for (int i = 0; i < NB; i++) begin
        r33  = {p.rem, p.lo[31]};
        p.lo = {p.lo[30:0], 1'b0};
        if (r33 >= {1'b0, p.den}) begin
          r33 = r33 - {1'b0, p.den};
          p.q = {p.q[30:0], 1'b1};
        end else begin
          p.q = {p.q[30:0], 1'b0};
        end
        p.rem = r33[31:0];
      end
      st_next[k] = p;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= st_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], din_vld};
    end
  end

  assign dout_vld = vld[NS-1];
  assign dout     = st[NS-1];

endmodule

// ===== rtl/fixed_point_alu_core.sv =====
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | in_data  (command, operand_a, operand_b)
// out     | output    | out_valid / out_ready | out_data (result_value, flags)
//
// one word accepted per cycle while the pipeline is not held; three front stages,
// 16 divider stages at two quotient bits each, a rounding stage and a saturation stage
// synchronous reset clears all valid bits, payload is not reset
// the whole pipeline holds while the output word waits, in_ready follows it
module fixed_point_alu_core #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_word_t out_data
);

  logic en;

  fpa_pkg::in_word_t s0;
  logic              s0_vld;
  fpa_pkg::pipe_t    s1, s1_next, s2, s2_next, sd, sr, sr_next;
  logic              s1_vld, s2_vld, sd_vld, sr_vld;
  fpa_pkg::out_word_t so, so_next;
  logic              so_vld;

  assign en       = !so_vld || out_ready;
  assign in_ready = en;

  // stage 1: simple results, flags, magnitudes
  always_comb begin
    logic signed [31:0] a, b;
    a = s0.operand_a;
    b = s0.operand_b;
    s1_next      = '0;
    s1_next.cmd  = s0.command;
    s1_next.lt   = a < b;
    s1_next.eq   = a == b;
    s1_next.gt   = a > b;
    s1_next.neg  = a[31] ^ b[31];
    s1_next.dz   = (s0.command == fpa_pkg::CMD_DIV) && (b == 32'sd0);
    s1_next.lo   = a[31] ? 32'(-a) : 32'(a);
    s1_next.den  = b[31] ? 32'(-b) : 32'(b);
    unique case (s0.command)
      fpa_pkg::CMD_ADD:     s1_next.res = 32'(a + b);
      fpa_pkg::CMD_SUB:     s1_next.res = 32'(a - b);
      fpa_pkg::CMD_MIN:     s1_next.res = (a < b) ? a : b;
      fpa_pkg::CMD_MAX:     s1_next.res = (a > b) ? a : b;
      fpa_pkg::CMD_INC:     s1_next.res = 32'(a + 32'sd1);
      fpa_pkg::CMD_DEC:     s1_next.res = 32'(a - 32'sd1);
      fpa_pkg::CMD_INT2FIX: s1_next.res = 32'(a <<< FRAC_BITS);
      fpa_pkg::CMD_FIX2INT: s1_next.res = 32'(a >>> FRAC_BITS);
      default:              s1_next.res = '0;
    endcase
  end

  // stage 2: product and divider set-up
  always_comb begin
    logic [63:0] num;
    s2_next      = s1;
    s2_next.prod = {32'b0, s1.lo} * {32'b0, s1.den};
    num          = {32'b0, s1.lo} << FRAC_BITS;
    s2_next.rem  = num[63:32];
    s2_next.lo   = num[31:0];
    s2_next.ovf  = num[63:32] >= s1.den;
    s2_next.q    = '0;
  end

  fpa_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .din_vld  (s2_vld),
    .din      (s2),
    .dout_vld (sd_vld),
    .dout     (sd)
  );

  // rounding: magnitude goes into prod
  always_comb begin
    sr_next = sd;
    if (sd.cmd == fpa_pkg::CMD_DIV) begin
      if (sd.ovf) begin
        sr_next.prod = '1;
      end else begin
        sr_next.prod = {32'b0, sd.q} +
                       64'(({sd.rem, 1'b0} >= {1'b0, sd.den}) ? 1 : 0);
      end
    end else begin
      sr_next.prod = (sd.prod >> FRAC_BITS) + {63'b0, sd.prod[FRAC_BITS-1]};
    end
  end

  // saturation and final select
  always_comb begin
    logic [31:0] sat;
    if (sr.neg) begin
      sat = (sr.prod >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-sr.prod[31:0]);
    end else begin
      sat = (sr.prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sr.prod[31:0];
    end
    so_next.a_less_b       = sr.lt;
    so_next.a_equal_b      = sr.eq;
    so_next.a_greater_b    = sr.gt;
    so_next.divide_by_zero = sr.dz;
    if (sr.cmd == fpa_pkg::CMD_MUL) begin
      so_next.result_value = sat;
    end else if (sr.cmd == fpa_pkg::CMD_DIV) begin
      so_next.result_value = sr.dz ? 32'sd0 : sat;
    end else begin
      so_next.result_value = sr.res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= in_data;
      s1 <= s1_next;
      s2 <= s2_next;
      sr <= sr_next;
      so <= so_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      sr_vld <= 1'b0;
      so_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      sr_vld <= sd_vld;
      so_vld <= sr_vld;
    end
  end

  assign out_valid = so_vld;
  assign out_data  = so;

endmodule
